FILE: sv/spm_pkg.sv
`timescale 1ns / 1ps
// spm_pkg: shared types and constants of the stream pattern masker
// used by spm_regs, stream_pattern_masker and the testbench; no dependencies

package spm_pkg;

    localparam int          PAT_BYTES   = 16;       // bytes held by the two pattern registers
    localparam logic [7:0]  STAR_BYTE   = 8'd42;    // replacement byte '*'
    localparam logic [4:0]  LEN_RESET   = 5'd1;
    localparam int          ADDR_W      = 5;

    // register index, taken from paddr[4:3]
    typedef enum logic [1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_PATTERN_LENGTH = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [63:0] pattern_low;
        logic [63:0] pattern_high;
        logic [4:0]  pattern_length;
    } cfg_t;

endpackage

FILE: sv/spm_regs.sv
`timescale 1ns / 1ps
// spm_regs: apb-style configuration registers of the stream pattern masker
// depends on spm_pkg

module spm_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spm_pkg::ADDR_W-1:0]  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready,
    output spm_pkg::cfg_t               cfg
);
    import spm_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:3]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_low    <= '0;
            cfg_reg.pattern_high   <= '0;
            cfg_reg.pattern_length <= LEN_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_PATTERN_LOW:    cfg_reg.pattern_low    <= pwdata;
                REG_PATTERN_HIGH:   cfg_reg.pattern_high   <= pwdata;
                REG_PATTERN_LENGTH: cfg_reg.pattern_length <= pwdata[4:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PATTERN_LOW:    prdata = cfg_reg.pattern_low;
            REG_PATTERN_HIGH:   prdata = cfg_reg.pattern_high;
            REG_PATTERN_LENGTH: prdata = {59'd0, cfg_reg.pattern_length};
            default:            prdata = '0;
        endcase
    end

endmodule

FILE: sv/spm_cell.sv
`timescale 1ns / 1ps
// spm_cell: one byte cell of the pending-byte shift line
// compares the byte it takes in against its expected pattern byte; depends on nothing

module spm_cell
(
    input  logic       clk,
    input  logic       shift_en,
    input  logic [7:0] d_in,
    input  logic [7:0] exp_byte,
    output logic [7:0] q,
    output logic       hit
);

    logic [7:0] byte_reg;

    // byte that moves in this cycle checked against this position of the pattern
    assign hit = (d_in == exp_byte);
    assign q   = byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= d_in;
        end
    end

endmodule

FILE: sv/stream_pattern_masker.sv
`timescale 1ns / 1ps
// stream_pattern_masker: top level, masks every leftmost non-overlapping pattern hit with '*'
// depends on spm_pkg, spm_regs, spm_cell
//
//  channel   dir  handshake             payload
//  s_*       in   s_tvalid / s_tready   s_tdata = data_byte, s_tlast = stream_end
//  m_*       out  m_tvalid / m_tready   m_tdata = out_byte, m_tuser = run_last,
//                                       m_tlast = out_stream_end
//  apb       in   psel & penable        pattern_low @0x00, pattern_high @0x08,
//                                       pattern_length @0x10, pready tied high
//
//  one item a cycle when each item gives at most one result and m_tready does not stall;
//  an item that gives n results holds s_tready low until its last result is produced, since
//  the single output register takes one byte a cycle; results pass the result counters,
//  then the output register; rst_n is asynchronous and clears the byte count, the result
//  counters and the output valid; a stall on m_tready stops result production and, once the
//  last result of an item is due, input acceptance

module stream_pattern_masker
#(
    parameter int MAX_PATTERN = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // slave stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,    // [7:0] data_byte
    input  logic                        s_tlast,    // stream_end
    // master stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,    // [7:0] out_byte
    output logic                        m_tuser,    // [0] run_last
    output logic                        m_tlast,    // out_stream_end
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spm_pkg::ADDR_W-1:0]  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);
    import spm_pkg::*;

    localparam int CW = $clog2(MAX_PATTERN + 1);                    // counts 0..MAX_PATTERN
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1; // cell index

    cfg_t                       cfg;
    logic [PAT_BYTES*8-1:0]     pat_bits;
    logic [CW-1:0]              len_eff;

    // shift line: newest byte in cell 0, oldest pending byte in cell cnt_reg-1
    logic [7:0]                 cell_q   [MAX_PATTERN];
    logic [7:0]                 cell_d   [MAX_PATTERN];
    logic [7:0]                 cell_exp [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]     cell_hit;
    logic [MAX_PATTERN-1:0]     cell_mask;

    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [CW-1:0]              raw_rem_reg, raw_rem_next;     // unchanged bytes still to send
    logic [CW-1:0]              star_rem_reg, star_rem_next;   // asterisks still to send
    logic                       end_reg, end_next;

    logic                       m_valid_reg, m_valid_next;
    logic [7:0]                 m_data_reg, m_data_next;
    logic                       m_user_reg, m_user_next;
    logic                       m_last_reg, m_last_next;

    logic                       rem_nz;
    logic                       rem_one;
    logic                       produce;
    logic                       accept;
    logic [CW-1:0]              cnt_e;
    logic [CW-1:0]              n_fill;
    logic                       full;
    logic [CW-1:0]              excess;
    logic                       match;
    logic [CW-1:0]              raw_plan;
    logic [CW-1:0]              star_plan;
    logic [IW-1:0]              oldest_idx;

    spm_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign pat_bits = {cfg.pattern_high, cfg.pattern_low};

    // length zero acts as one, anything above the line depth as the full depth
    always_comb
    begin
        if (cfg.pattern_length == 5'd0)
            len_eff = CW'(1);
        else if (cfg.pattern_length > 5'(MAX_PATTERN))
            len_eff = CW'(MAX_PATTERN);
        else
            len_eff = CW'(cfg.pattern_length);
    end

    // cell j holds the byte j places back from the newest, so it faces pattern byte len-1-j
    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_cell
        logic [CW-1:0] k_full;
        logic [3:0]    k;

        assign k_full       = len_eff - CW'(1) - CW'(j);
        assign k            = 4'(k_full);
        assign cell_exp[j]  = pat_bits[k*8 +: 8];
        assign cell_mask[j] = (CW'(j) < len_eff);

        if (j == 0)
        begin : g_head
            assign cell_d[j] = s_tdata;
        end
        else
        begin : g_link
            assign cell_d[j] = cell_q[j-1];
        end

        spm_cell u_cell
        (
            .clk      (clk),
            .shift_en (accept),
            .d_in     (cell_d[j]),
            .exp_byte (cell_exp[j]),
            .q        (cell_q[j]),
            .hit      (cell_hit[j])
        );
    end

    // result sequencing: the output register takes one result a cycle unless m_tready stalls it
    assign rem_nz   = (raw_rem_reg != '0) || (star_rem_reg != '0);
    assign rem_one  = ((raw_rem_reg == CW'(1)) && (star_rem_reg == '0))
                   || ((raw_rem_reg == '0) && (star_rem_reg == CW'(1)));
    assign produce  = rem_nz && (!m_valid_reg || m_tready);
    // a new item may enter in the cycle the last result of the previous one is produced
    assign s_tready = !rem_nz || (rem_one && produce);
    assign accept   = s_tvalid && s_tready;

    // plan for the incoming item, seen from the count after this cycle's pop
    assign cnt_e    = produce ? (cnt_reg - CW'(1)) : cnt_reg;
    assign n_fill   = cnt_e + CW'(1);
    assign full     = (n_fill >= len_eff);
    assign excess   = full ? (n_fill - len_eff) : '0;
    assign match    = full && (&(cell_hit | ~cell_mask));

    always_comb
    begin
        if (match)
        begin
            raw_plan  = excess;
            star_plan = len_eff;
        end
        else
        begin
            star_plan = '0;
            if (s_tlast)
                raw_plan = n_fill;                  // flush everything pending
            else if (full)
                raw_plan = excess + CW'(1);         // overflow bytes and the oldest
            else
                raw_plan = '0;
        end
    end

    assign oldest_idx = IW'(cnt_reg - CW'(1));

    always_comb
    begin
        raw_rem_next  = raw_rem_reg;
        star_rem_next = star_rem_reg;
        end_next      = end_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        m_last_next   = m_last_reg;
        // every result, asterisk or not, retires one pending byte
        cnt_next      = cnt_e + (accept ? CW'(1) : '0);

        if (m_tready)
            m_valid_next = 1'b0;

        if (produce)
        begin
            m_valid_next = 1'b1;
            m_user_next  = rem_one;
            m_last_next  = rem_one && end_reg;
            if (raw_rem_reg != '0)
            begin
                m_data_next  = cell_q[oldest_idx];
                raw_rem_next = raw_rem_reg - CW'(1);
            end
            else
            begin
                m_data_next   = STAR_BYTE;
                star_rem_next = star_rem_reg - CW'(1);
            end
        end

        if (accept)
        begin
            raw_rem_next  = raw_plan;
            star_rem_next = star_plan;
            end_next      = s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            raw_rem_reg  <= '0;
            star_rem_reg <= '0;
            end_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            raw_rem_reg  <= raw_rem_next;
            star_rem_reg <= star_rem_next;
            end_reg      <= end_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // the line never holds more bytes than it has cells
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_PATTERN))
        else $error("pending count beyond line depth");

    // results still owed never outnumber the bytes they retire
    a_rem_cover: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, raw_rem_reg} + {1'b0, star_rem_reg}) <= {1'b0, cnt_reg})
        else $error("more results owed than pending bytes");

    // input is taken only with at most the final result outstanding
    a_ready_rem: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!rem_nz || rem_one))
        else $error("ready while several results outstanding");

    // the result marked last of its item leaves nothing behind unless a new item entered
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (produce && rem_one && !accept) |=> !rem_nz)
        else $error("results left after the last one of an item");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for stream_pattern_masker, byte streams in, masked bytes out
// depends on spm_pkg and stream_pattern_masker; predicts each masked byte and checks it in order

module testbench;

    import spm_pkg::*;

    localparam int MAX_WINDOW   = 16;
    localparam int DRAIN_CYCLES = 10;       // drain time, well past an item's path to its result
    localparam int LONG_HOLD    = 100;      // receiver hold-off that backs up the input
    localparam int RANDOM_ITEMS = 440;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_byte_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       stream_end;
    } masked_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] data_byte
    logic        s_tlast = 1'b0;    // stream_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [7:0] out_byte
    logic        m_tuser;           // [0] run_last
    logic        m_tlast;           // out_stream_end
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    stream_pattern_masker DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // bench copy of the pattern registers and the pending window
    logic [63:0] pat_lo = '0;
    logic [63:0] pat_hi = '0;
    logic [4:0]  pat_len = LEN_RESET;
    logic [7:0]  win [MAX_WINDOW];
    int          win_cnt = 0;

    text_byte_t   text_pending [$];
    masked_byte_t masked_due [$];
    int           bytes_sent = 0;
    int           bytes_taken = 0;
    int           random_items = 0;
    int           errors = 0;
    int           hold_req = 0;
    int           hold_served = 0;
    logic [7:0]   alph [3];

    function automatic int eff_len();
        if (pat_len == 5'd0)
            return 1;
        if (pat_len > MAX_WINDOW)
            return MAX_WINDOW;
        return int'(pat_len);
    endfunction

    function automatic logic [7:0] pattern_byte(input int idx);
        if (idx < 8)
            return pat_lo[idx*8 +: 8];
        return pat_hi[(idx-8)*8 +: 8];
    endfunction

    function automatic logic [7:0] pop_window();
        logic [7:0] b;
        b = win[0];
        for (int i = 0; i < MAX_WINDOW-1; i++)
            win[i] = win[i+1];
        win[MAX_WINDOW-1] = 8'd0;
        if (win_cnt > 0)
        begin
            win_cnt--;
            win[win_cnt] = 8'd0;
        end
        return b;
    endfunction

    // one accepted text byte: push the masked bytes it releases
    task automatic mask_byte(input logic [7:0] b, input logic endf);
        logic [7:0]   outs [$];
        int           len;
        bit           hit;
        masked_byte_t mb;
        len = eff_len();
        if (win_cnt >= MAX_WINDOW)
            outs.push_back(pop_window());
        win[win_cnt] = b;
        win_cnt++;
        // a shrunk length first flushes the oldest extra bytes untouched
        while (win_cnt > len)
            outs.push_back(pop_window());
        if (win_cnt == len)
        begin
            hit = 1'b1;
            for (int i = 0; i < len; i++)
                if (win[i] != pattern_byte(i))
                    hit = 1'b0;
            if (hit)
            begin
                repeat (len) outs.push_back(STAR_BYTE);
                for (int i = 0; i < MAX_WINDOW; i++)
                    win[i] = 8'd0;
                win_cnt = 0;
            end
            else
                outs.push_back(pop_window());
        end
        if (endf)
            while (win_cnt > 0)
                outs.push_back(pop_window());
        while (outs.size() > MAX_WINDOW)
            void'(outs.pop_back());
        foreach (outs[i])
        begin
            mb.data       = outs[i];
            mb.run_last   = (i == outs.size() - 1);
            mb.stream_end = (i == outs.size() - 1) && endf;
            masked_due.push_back(mb);
        end
    endtask

    // sender: one item at a time from text_pending, random gap after each
    int         drv_gap = 0;
    bit         drv_busy = 1'b0;
    text_byte_t drv_cur;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            drv_gap  = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                mask_byte(s_tdata, s_tlast);
                bytes_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (drv_gap > 0)
                begin
                    drv_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (text_pending.size() > 0)
                begin
                    drv_cur = text_pending.pop_front();
                    s_tdata  <= drv_cur.data;
                    s_tlast  <= drv_cur.last;
                    s_tvalid <= 1'b1;
                    // now and then switch between gapless stretches and random gaps
                    if ($urandom_range(0, 31) == 0)
                        drv_busy = !drv_busy;
                    drv_gap = drv_busy ? 0 : $urandom_range(0, 5);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: checks each masked byte, random stall after each, long hold on request
    int  mon_wait = 0;
    bit  mon_busy = 1'b0;
    masked_byte_t mon_exp;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            mon_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (masked_due.size() == 0)
                begin
                    $error("unexpected item: out_byte %0d", m_tdata);
                    errors++;
                end
                else
                begin
                    mon_exp = masked_due.pop_front();
                    if (m_tdata !== mon_exp.data)
                    begin
                        $error("out_byte: expected %0d, got %0d", mon_exp.data, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== mon_exp.run_last)
                    begin
                        $error("run_last: expected %0d, got %0d", mon_exp.run_last, m_tuser);
                        errors++;
                    end
                    if (m_tlast !== mon_exp.stream_end)
                    begin
                        $error("out_stream_end: expected %0d, got %0d",
                               mon_exp.stream_end, m_tlast);
                        errors++;
                    end
                end
                if ($urandom_range(0, 31) == 0)
                    mon_busy = !mon_busy;
                mon_wait = mon_busy ? 0 : $urandom_range(0, 5);
            end
            if (hold_served != hold_req)
            begin
                hold_served = hold_req;
                mon_wait = LONG_HOLD;
            end
            if (mon_wait > 0)
            begin
                mon_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PATTERN_LOW:    pat_lo = value;
            REG_PATTERN_HIGH:   pat_hi = value;
            REG_PATTERN_LENGTH: pat_len = value[4:0];
            default: ;
        endcase
    endtask

    task automatic push_byte(input logic [7:0] data, input logic last);
        text_byte_t tb;
        tb.data = data;
        tb.last = last;
        text_pending.push_back(tb);
        bytes_sent++;
    endtask

    // block idle: every item taken, every masked byte seen, pipeline drained
    task automatic settle();
        while (bytes_taken != bytes_sent || masked_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic new_pattern();
        int          r;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  raw;
        r = $urandom_range(0, 19);
        if (r == 0)
            raw = 5'd0;
        else if (r == 1)
            raw = 5'($urandom_range(17, 31));
        else if (r < 4)
            raw = 5'd16;
        else if (r < 10)
            raw = 5'($urandom_range(1, 4));
        else
            raw = 5'($urandom_range(1, 16));
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        alph[0] = 8'($urandom_range(0, 255));
        alph[1] = alph[0] + 8'd1;
        alph[2] = 8'($urandom_range(0, 255));
        // a small alphabet makes self-overlapping patterns and near misses common
        if ($urandom_range(0, 2) != 0)
            for (int i = 0; i < 8; i++)
            begin
                lo[i*8 +: 8] = alph[$urandom_range(0, 2)];
                hi[i*8 +: 8] = alph[$urandom_range(0, 2)];
            end
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_PATTERN_LENGTH, {59'd0, raw});
    endtask

    function automatic text_byte_t text_of(input logic [7:0] data);
        text_byte_t tb;
        tb.data = data;
        tb.last = ($urandom_range(0, 24) == 0);
        return tb;
    endfunction

    // a run of pattern copies, prefixes and filler, ending a stream or not
    task automatic random_phase(input int n_target);
        text_byte_t seq [$];
        int         r;
        int         len;
        int         cut;
        len = eff_len();
        while (seq.size() < n_target)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
                for (int k = 0; k < len; k++)
                    seq.push_back(text_of(pattern_byte(k)));
            else if (r < 7)
            begin
                cut = $urandom_range(1, len);
                for (int k = 0; k < cut; k++)
                    seq.push_back(text_of(pattern_byte(k)));
            end
            else if (r < 9)
                repeat ($urandom_range(1, 4)) seq.push_back(text_of(alph[$urandom_range(0, 2)]));
            else
                repeat ($urandom_range(1, 3)) seq.push_back(text_of(8'($urandom_range(0, 255))));
        end
        // leaving bytes pending lets the next setting shrink the window mid-stream
        seq[seq.size()-1].last = ($urandom_range(0, 2) != 0);
        foreach (seq[i])
            push_byte(seq[i].data, seq[i].last);
        random_items += seq.size();
    endtask

    initial
    begin
        int phase_no;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset setting: one-byte pattern of zero
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        settle();

        // length zero behaves as one, all-ones pattern word
        write_reg(REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PATTERN_HIGH, 64'h0);
        write_reg(REG_PATTERN_LENGTH, 64'd0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h12, 1'b1);
        settle();

        // two bytes of a three-byte pattern give no result yet
        write_reg(REG_PATTERN_LOW, 64'h0000_0000_0063_6261);
        write_reg(REG_PATTERN_LENGTH, 64'd3);
        push_byte(8'h61, 1'b0);
        push_byte(8'h62, 1'b0);
        settle();

        // shrink to one byte with two pending: old bytes out, then the hit
        write_reg(REG_PATTERN_LOW, 64'h0000_0000_0000_0078);
        write_reg(REG_PATTERN_LENGTH, 64'd1);
        push_byte(8'h78, 1'b1);
        settle();

        // length above the maximum acts as sixteen; full-width hit gives sixteen stars
        write_reg(REG_PATTERN_LOW, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_PATTERN_HIGH, 64'hFEDC_BA98_7654_3210);
        write_reg(REG_PATTERN_LENGTH, 64'd31);
        for (int k = 0; k < MAX_WINDOW; k++)
            push_byte(pattern_byte(k), k == MAX_WINDOW - 1);

        phase_no = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            settle();
            if (phase_no == 0 || $urandom_range(0, 3) != 0)
                new_pattern();
            else
                write_reg(REG_PATTERN_LENGTH, 64'($urandom_range(1, 16)));
            // long receiver hold-offs while the sender keeps offering items
            if (phase_no == 1 || phase_no == 7)
                hold_req++;
            random_phase((phase_no == 1 || phase_no == 7) ? 40 : $urandom_range(8, 40));
            phase_no++;
        end
        settle();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
